>>> hdl/i2c_target_write_receiver_macros.svh
// Assertion macros used by the checker file of the I2C target write receiver.
`ifndef I2C_TARGET_WRITE_RECEIVER_MACROS_SVH
`define I2C_TARGET_WRITE_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CTWR_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CTWR_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> hdl/i2ctwr_pkg.sv
// Package with the word types, phase encoding and constants of the I2C write receiver.
`default_nettype none

package i2ctwr_pkg;

    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;

    localparam logic [ADDR_W-1:0] ADDR_RESET    = 7'd64;
    localparam logic [CNT_W-1:0]  BITS_PER_BYTE = 4'd8;

    // Acknowledge sub-steps kept in the bit counter while in the acknowledge phase.
    localparam logic [CNT_W-1:0] ACK_WAIT_LOW  = 4'd0;
    localparam logic [CNT_W-1:0] ACK_PULL_LOW  = 4'd1;
    localparam logic [CNT_W-1:0] ACK_PULL_HIGH = 4'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_ACK  = 3'd2,
        PH_DATA = 3'd3
    } phase_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
    } sample_word_t;

    typedef struct packed {
        logic              sda_pull_low;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic              byte_is_address;
    } result_word_t;

endpackage

`default_nettype wire

>>> hdl/i2c_target_write_receiver.sv
// Top level of the I2C target write receiver: bus sampler, address match and byte reporting.
//
//  Channel    Direction  Handshake                Word
//  in         sink       in_valid / in_ready      sample_word_t (scl_level, sda_level)
//  out        source     out_valid / out_ready    result_word_t (pull, byte flags, byte)
//  cfg        sink       cfg_write, no wait       7-bit target address
//
// Every accepted sample word produces exactly one result word, in the next cycle.
// A new sample word can be accepted in every cycle; the result register is the only
// stage, and the bus state registers are updated in the same edge that takes the word.
// When the result register is full and out_ready is low, in_ready drops and the bus
// state is held until the result is taken.
// Reset (rst_n low, asynchronous) returns to idle, clears the counters and sets the
// target address to 64.
`default_nettype none

module i2c_target_write_receiver (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire i2ctwr_pkg::sample_word_t         in_word,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output i2ctwr_pkg::result_word_t              out_word,
    input  wire logic                             cfg_write,
    input  wire logic [i2ctwr_pkg::ADDR_W-1:0]    cfg_data
);

    // Configuration register.
    logic [i2ctwr_pkg::ADDR_W-1:0] target_address_reg;

    // Bus receiver state.
    i2ctwr_pkg::phase_t            phase_reg,          phase_next;
    logic [i2ctwr_pkg::CNT_W-1:0]  bit_counter_reg,    bit_counter_next;
    logic [i2ctwr_pkg::BYTE_W-1:0] shift_byte_reg,     shift_byte_next;
    logic                          clock_low_seen_reg, clock_low_seen_next;

    // Result register.
    logic                          out_valid_reg;
    i2ctwr_pkg::result_word_t      out_word_reg,       out_word_next;

    logic                          in_accept;
    logic                          scl;
    logic                          sda;
    logic                          bit_edge;
    logic [i2ctwr_pkg::CNT_W-1:0]  count_inc;
    logic [i2ctwr_pkg::BYTE_W-1:0] shift_taken;
    logic                          byte_done;
    logic                          addr_match;

    // The input side moves whenever the result register is empty or being emptied.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign scl = in_word.scl_level;
    assign sda = in_word.sda_level;

    // A bit is taken on the first sample with SCL high after SCL was seen low.
    assign bit_edge    = scl && clock_low_seen_reg;
    assign count_inc   = bit_counter_reg + 4'd1;
    assign shift_taken = {shift_byte_reg[i2ctwr_pkg::BYTE_W-2:0], sda};
    assign byte_done   = bit_edge && (count_inc >= i2ctwr_pkg::BITS_PER_BYTE);
    // Only a write request (R/W bit low) to our address is a match.
    assign addr_match  = (shift_taken == {target_address_reg, 1'b0});

    // Next-state logic for the phase and the shift datapath.
    always_comb
    begin
        phase_next          = phase_reg;
        bit_counter_next    = bit_counter_reg;
        shift_byte_next     = shift_byte_reg;
        clock_low_seen_next = clock_low_seen_reg;
        case (phase_reg)
            i2ctwr_pkg::PH_ADDR,
            i2ctwr_pkg::PH_DATA:
            begin
                if (!scl)
                begin
                    clock_low_seen_next = 1'b1;
                end
                else if (clock_low_seen_reg)
                begin
                    clock_low_seen_next = 1'b0;
                    shift_byte_next     = shift_taken;
                    bit_counter_next    = count_inc;
                    if (byte_done)
                    begin
                        bit_counter_next = '0;
                        if (phase_reg == i2ctwr_pkg::PH_DATA || addr_match)
                        begin
                            phase_next = i2ctwr_pkg::PH_ACK;
                        end
                        else
                        begin
                            phase_next = i2ctwr_pkg::PH_IDLE;
                        end
                    end
                end
            end
            i2ctwr_pkg::PH_ACK:
            begin
                if (bit_counter_reg == i2ctwr_pkg::ACK_WAIT_LOW)
                begin
                    if (!scl)
                    begin
                        bit_counter_next = i2ctwr_pkg::ACK_PULL_LOW;
                    end
                end
                else if (bit_counter_reg == i2ctwr_pkg::ACK_PULL_LOW)
                begin
                    if (scl)
                    begin
                        bit_counter_next = i2ctwr_pkg::ACK_PULL_HIGH;
                    end
                end
                else if (!scl)
                begin
                    // The low that ends the acknowledge clock also counts as the
                    // low before the first data bit.
                    phase_next          = i2ctwr_pkg::PH_DATA;
                    bit_counter_next    = '0;
                    shift_byte_next     = '0;
                    clock_low_seen_next = 1'b1;
                end
            end
            default:
            begin
                // Idle, and any unused phase code, waits for SCL high with SDA low.
                phase_next = i2ctwr_pkg::PH_IDLE;
                if (scl && !sda)
                begin
                    phase_next          = i2ctwr_pkg::PH_ADDR;
                    bit_counter_next    = '0;
                    shift_byte_next     = '0;
                    clock_low_seen_next = 1'b0;
                end
            end
        endcase
    end

    // Output logic: the result word for the sample being accepted.
    always_comb
    begin
        out_word_next = '0;
        case (phase_reg)
            i2ctwr_pkg::PH_ADDR:
            begin
                out_word_next.byte_valid      = byte_done;
                out_word_next.byte_is_address = byte_done;
                out_word_next.byte_value      = byte_done ? shift_taken : '0;
            end
            i2ctwr_pkg::PH_DATA:
            begin
                out_word_next.byte_valid = byte_done;
                out_word_next.byte_value = byte_done ? shift_taken : '0;
            end
            i2ctwr_pkg::PH_ACK:
            begin
                // SDA is held low from the first SCL low through the ninth SCL high.
                if (bit_counter_reg == i2ctwr_pkg::ACK_WAIT_LOW)
                begin
                    out_word_next.sda_pull_low = !scl;
                end
                else if (bit_counter_reg == i2ctwr_pkg::ACK_PULL_LOW)
                begin
                    out_word_next.sda_pull_low = 1'b1;
                end
                else
                begin
                    out_word_next.sda_pull_low = scl;
                end
            end
            default:
            begin
                out_word_next = '0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= i2ctwr_pkg::ADDR_RESET;
        end
        else if (cfg_write)
        begin
            target_address_reg <= cfg_data;
        end
    end

    // Bus state advances only on an accepted sample word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2ctwr_pkg::PH_IDLE;
            bit_counter_reg    <= '0;
            shift_byte_reg     <= '0;
            clock_low_seen_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg          <= phase_next;
            bit_counter_reg    <= bit_counter_next;
            shift_byte_reg     <= shift_byte_next;
            clock_low_seen_reg <= clock_low_seen_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

>>> hdl/i2ctwr_checker.sv
// Port-level checker for the I2C target write receiver, with its bind statement.
`default_nettype none
`include "i2c_target_write_receiver_macros.svh"

module i2ctwr_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire i2ctwr_pkg::result_word_t out_word
);

    // A stalled result word stays put until it is taken.
    `I2CTWR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_word), "result word changed while stalled")

    // With the result register empty the block must take a sample word.
    `I2CTWR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready,
        "input not ready while output is empty")

    // Every accepted sample word shows up as a result word on the next cycle.
    `I2CTWR_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid,
        "no result word after an accepted sample word")

    // Byte fields are zero unless a byte is reported.
    `I2CTWR_ASSERT_NOW(a_byte_fields_clear, clk, rst_n, out_valid && !out_word.byte_valid,
        (out_word.byte_value == '0) && !out_word.byte_is_address,
        "byte fields set without a byte")

    // A byte is never completed during an acknowledge clock.
    `I2CTWR_ASSERT_NOW(a_no_pull_on_byte, clk, rst_n, out_valid && out_word.byte_valid,
        !out_word.sda_pull_low, "SDA pulled on a completed byte")

endmodule

bind i2c_target_write_receiver i2ctwr_checker u_i2ctwr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

`default_nettype wire

>>> dv/i2c_target_write_receiver_tb.sv
// Self-checking testbench for the I2C target write receiver, driven by sampled bus words.
`timescale 1ns / 1ps

module i2c_target_write_receiver_tb;

    // A stretch this long with no word moving on either channel means the block hung.
    localparam int STALL_LIMIT = 500;
    // Length of the single long receiver hold-off used to back the block up.
    localparam int LONG_HOLD = 90;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    i2ctwr_pkg::sample_word_t in_word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    i2ctwr_pkg::result_word_t out_word;
    logic                          cfg_write = 1'b0;
    logic [i2ctwr_pkg::ADDR_W-1:0] cfg_data = '0;

    // Bus samples waiting to be offered, and the result words predicted for accepted ones.
    i2ctwr_pkg::sample_word_t line_samples[$];
    i2ctwr_pkg::result_word_t pending_results[$];

    int samples_queued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Handshake completions seen at the last rising edge, used by the falling-edge drivers.
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    // Sender and receiver pacing.
    int send_gap = 0;
    int send_calm = 0;
    int take_wait = 0;
    int recv_calm = 0;
    int hold_left = 0;
    int hold_trigger = 32'h7fff_ffff;
    logic hold_used = 1'b0;

    // Our own copy of the receiver state, stepped once per accepted sample word.
    i2ctwr_pkg::phase_t             bus_phase;
    logic [i2ctwr_pkg::CNT_W-1:0]   bit_tally;
    logic [i2ctwr_pkg::BYTE_W-1:0]  rx_byte;
    logic                           low_seen;
    logic [i2ctwr_pkg::ADDR_W-1:0]  line_addr;

    i2c_target_write_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Steps the receiver state by one bus sample and returns the result word it
    // must produce. Address and data bytes share the shift-in logic; a bit is taken
    // only on the first SCL-high sample after SCL was seen low.
    function automatic i2ctwr_pkg::result_word_t next_line_result(
        i2ctwr_pkg::sample_word_t s);
        i2ctwr_pkg::result_word_t r;
        logic                     byte_done;
        r = '0;
        byte_done = 1'b0;
        case (bus_phase)
            i2ctwr_pkg::PH_ADDR, i2ctwr_pkg::PH_DATA:
            begin
                if (!s.scl_level)
                    low_seen = 1'b1;
                else if (low_seen)
                begin
                    low_seen = 1'b0;
                    rx_byte = {rx_byte[i2ctwr_pkg::BYTE_W-2:0], s.sda_level};
                    bit_tally = bit_tally + 4'd1;
                    byte_done = (bit_tally >= i2ctwr_pkg::BITS_PER_BYTE);
                end
                if (byte_done)
                begin
                    r.byte_valid = 1'b1;
                    r.byte_value = rx_byte;
                    r.byte_is_address = (bus_phase == i2ctwr_pkg::PH_ADDR);
                    bit_tally = '0;
                    low_seen = 1'b0;
                    // Only a write to our own address is acknowledged; a read request
                    // or a foreign address sends the receiver back to idle.
                    if (bus_phase == i2ctwr_pkg::PH_ADDR && rx_byte != {line_addr, 1'b0})
                        bus_phase = i2ctwr_pkg::PH_IDLE;
                    else
                        bus_phase = i2ctwr_pkg::PH_ACK;
                end
            end
            i2ctwr_pkg::PH_ACK:
            begin
                // The acknowledge pull starts at the first SCL low after the byte,
                // lasts through the ninth SCL high and ends at the next SCL low, which
                // also counts as the low before the first data bit.
                if (bit_tally == i2ctwr_pkg::ACK_WAIT_LOW)
                begin
                    if (!s.scl_level)
                    begin
                        bit_tally = i2ctwr_pkg::ACK_PULL_LOW;
                        r.sda_pull_low = 1'b1;
                    end
                end
                else if (bit_tally == i2ctwr_pkg::ACK_PULL_LOW)
                begin
                    r.sda_pull_low = 1'b1;
                    if (s.scl_level)
                        bit_tally = i2ctwr_pkg::ACK_PULL_HIGH;
                end
                else if (!s.scl_level)
                begin
                    bus_phase = i2ctwr_pkg::PH_DATA;
                    bit_tally = '0;
                    rx_byte = '0;
                    low_seen = 1'b1;
                end
                else
                begin
                    r.sda_pull_low = 1'b1;
                end
            end
            default:
            begin
                bus_phase = i2ctwr_pkg::PH_IDLE;
                if (s.scl_level && !s.sda_level)
                begin
                    bus_phase = i2ctwr_pkg::PH_ADDR;
                    bit_tally = '0;
                    rx_byte = '0;
                    low_seen = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    // Draws the pause before the next word: mostly a uniformly drawn pause, with occasional
    // calm stretches where words follow back to back.
    function automatic int draw_pause(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns, result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    // Rising edge: check result words against the oldest prediction, then predict
    // the result of a sample word taken at this same edge. Popping before pushing
    // keeps the order right when both channels move together.
    always @(posedge clk)
    begin : line_checker
        i2ctwr_pkg::result_word_t want;
        if (!rst_n)
        begin
            bus_phase = i2ctwr_pkg::PH_IDLE;
            bit_tally = '0;
            rx_byte = '0;
            low_seen = 1'b0;
            line_addr = i2ctwr_pkg::ADDR_RESET;
            in_took <= 1'b0;
            out_took <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word %h with nothing expected", out_word));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_word.sda_pull_low !== want.sda_pull_low)
                        report_mismatch($sformatf("sda_pull_low %b, expected %b",
                            out_word.sda_pull_low, want.sda_pull_low));
                    if (out_word.byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %b, expected %b",
                            out_word.byte_valid, want.byte_valid));
                    if (out_word.byte_value !== want.byte_value)
                        report_mismatch($sformatf("byte_value %h, expected %h",
                            out_word.byte_value, want.byte_value));
                    if (out_word.byte_is_address !== want.byte_is_address)
                        report_mismatch($sformatf("byte_is_address %b, expected %b",
                            out_word.byte_is_address, want.byte_is_address));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(next_line_result(in_word));
            // The address register takes a write at this edge, after any sample
            // word accepted here was already stepped with the old address.
            if (cfg_write)
                line_addr = cfg_data;
            in_took <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
        end
    end

    // Watchdog: the run ends as failed if no word moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sender: offers queued sample words on the falling edge. Valid stays up with
    // the word unchanged until it is taken, then the drawn pause runs out.
    always @(negedge clk)
    begin : sample_sender
        logic                     next_valid;
        i2ctwr_pkg::sample_word_t next_word;
        next_valid = in_valid;
        next_word = in_word;
        if (rst_n)
        begin
            if (in_took)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (line_samples.size() > 0)
                begin
                    next_word = line_samples.pop_front();
                    next_valid = 1'b1;
                    send_gap = draw_pause(send_calm);
                end
            end
        end
        in_valid <= next_valid;
        in_word <= next_word;
    end

    // Receiver: stalls a drawn number of cycles before each result word, and once
    // in the run holds off long enough for the block to fill and stall its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
                take_wait = draw_pause(recv_calm);
            if (!hold_used && results_seen >= hold_trigger)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_sample(logic scl, logic sda);
        i2ctwr_pkg::sample_word_t w;
        w.scl_level = scl;
        w.sda_level = sda;
        line_samples.push_back(w);
        samples_queued++;
    endtask

    // One bus clock carrying a data bit. SDA may change freely while SCL is low;
    // extra SCL-high samples may toggle SDA, which looks like a stop or a repeated
    // start and must be ignored by the receiver.
    task automatic push_bit(logic b, int nlo, int nhi);
        push_sample(1'b0, 1'($urandom_range(0, 1)));
        for (int i = 1; i < nlo; i++)
            push_sample(1'b0, b);
        push_sample(1'b1, b);
        for (int i = 1; i < nhi; i++)
            push_sample(1'b1, ($urandom_range(0, 3) == 0) ? ~b : b);
    endtask

    // A byte MSB first. When the receiver drops back to idle right after the byte,
    // the last bit gets a single high sample so that a low SDA is not seen as a start.
    task automatic push_byte(logic [7:0] v, logic ends_in_idle);
        for (int i = 7; i >= 0; i--)
            push_bit(v[i], $urandom_range(1, 2),
                (ends_in_idle && i == 0) ? 1 : $urandom_range(1, 3));
    endtask

    task automatic push_ack_clock(logic sda);
        repeat ($urandom_range(1, 2)) push_sample(1'b0, sda);
        repeat ($urandom_range(1, 3)) push_sample(1'b1, sda);
    endtask

    task automatic push_start();
        repeat ($urandom_range(1, 3)) push_sample(1'b1, 1'b1);
        repeat ($urandom_range(1, 2)) push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b0);
    endtask

    // Transfers that must not be acknowledged for target t: read requests to t,
    // addresses one bit away from t, and random foreign addresses.
    task automatic push_foreign_frames(logic [i2ctwr_pkg::ADDR_W-1:0] t, int count);
        logic [7:0] v;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: v = {t, 1'b1};
                1: v = {t ^ (7'd1 << $urandom_range(0, 6)), 1'b0};
                default:
                begin
                    do
                        v = 8'($urandom);
                    while (v == {t, 1'b0});
                end
            endcase
            push_start();
            push_byte(v, 1'b1);
            push_ack_clock(1'b1);
            repeat ($urandom_range(0, 2))
            begin
                push_sample(1'b0, 1'($urandom_range(0, 1)));
                push_sample(1'b1, 1'b1);
            end
        end
    endtask

    // Once the address matched, the receiver stays in the data phase for good, so
    // everything here is fair game: acknowledged bytes and raw bus noise.
    task automatic push_data_traffic(int upto);
        while (samples_queued < upto)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(3, 12))
                    push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                push_byte(8'($urandom), 1'b0);
                push_ack_clock(1'b0);
            end
        end
    endtask

    // Sender pause: every queued word taken and every result word checked.
    task automatic wait_all_results();
        while (results_seen != samples_queued)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_target_address(logic [i2ctwr_pkg::ADDR_W-1:0] a);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= a;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Bits of the read request to the reset address, MSB first.
    function automatic logic addr_read_bit(int i);
        logic [7:0] v;
        v = {i2ctwr_pkg::ADDR_RESET, 1'b1};
        return v[i];
    endfunction

    initial
    begin : stimulus
        logic [i2ctwr_pkg::ADDR_W-1:0] addr;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset address: every SCL/SDA pair in idle, then
        // a start and a read request to address 64, one sample per level, which is
        // reported as an address byte and not acknowledged.
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        for (int i = 7; i >= 0; i--)
            push_bit(addr_read_bit(i), 1, 1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_foreign_frames(i2ctwr_pkg::ADDR_RESET, 4);
        wait_all_results();

        // Both extremes of the address, then two random ones.
        write_target_address('0);
        push_foreign_frames('0, 4);
        wait_all_results();
        write_target_address('1);
        push_foreign_frames('1, 4);
        wait_all_results();
        repeat (2)
        begin
            addr = 7'($urandom);
            write_target_address(addr);
            push_foreign_frames(addr, 4);
            wait_all_results();
        end

        // Back to address 64 and a matching write; the data bytes start with the
        // all-zeros and all-ones values.
        write_target_address(i2ctwr_pkg::ADDR_RESET);
        push_start();
        push_byte({i2ctwr_pkg::ADDR_RESET, 1'b0}, 1'b0);
        push_ack_clock(1'b0);
        push_byte(8'h00, 1'b0);
        push_ack_clock(1'b0);
        push_byte(8'hff, 1'b0);
        push_ack_clock(1'b0);
        push_data_traffic(800);
        // The long receiver hold-off falls while plenty of words are still queued.
        hold_trigger <= results_seen + 30;
        wait_all_results();
        push_data_traffic(1150);
        wait_all_results();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
